FILE: src/hnfp_pkg.sv
// Shared constants for the HEVC NAL fragmentation-unit packetiser.
// No dependencies; imported by hevc_nal_fu_packetizer.
package hnfp_pkg;

  localparam int unsigned LEN_W        = 16;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned QDEPTH       = 4;

  localparam logic [LEN_W-1:0] MAXP_RESET = 16'd1400;
  localparam logic [LEN_W-1:0] MAXP_MIN   = 16'd4;
  localparam logic [LEN_W-1:0] HDR_SIZE   = 16'd3;

  // FU payload header: type 49 shifted into the type field, then layer/TID byte
  localparam logic [7:0] FU_TYPE_BYTE = 8'(49 << 1);
  localparam logic [7:0] FU_TID_BYTE  = 8'd1;
  localparam logic [5:0] TYPE_MASK    = 6'h3F;
  localparam logic [7:0] S_BIT        = 8'(1 << 7);
  localparam logic [7:0] E_BIT        = 8'(1 << 6);

  localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
  localparam logic [CNT_W-1:0] CNT_FU   = 3'd4;

endpackage

FILE: src/hevc_nal_fu_packetizer.sv
// HEVC NAL unit to RTP payload packetiser with fragmentation units.
// Depends on hnfp_pkg for header constants and widths.
//
// Usage
//   Input channel (in_*): one NAL byte per request, with the NAL's total
//   length and an end-of-frame flag held across all its bytes. The block
//   stalls the source with in_stall.
//   Result channel (out_*): one payload byte per request, with packet_end on
//   the last byte of each RTP payload and frame_marker with it on the frame's
//   last packet. The sink holds results back with out_stall.
//   Configuration: cfg_wr_en/cfg_wr_data write max_payload; write only idle.
// Flow
//   A request is decoded in the cycle it is taken; its bytes appear from the
//   next cycle, one per cycle unless out_stall holds them. Pass-through and
//   continuing fragment bytes run at one request per cycle when not stalled.
//   A fragment-opening request fills the four-entry queue with three FU
//   header bytes and its data byte; no request is taken until its last byte leaves.
// Reset
//   Synchronous, active low: queue empties, NAL tracking returns to the start
//   of a NAL, max_payload returns to 1400.
// Stall
//   While out_stall is high the head byte holds; a new request is taken only
//   when the queue is empty or its last byte leaves in the same cycle.
module hevc_nal_fu_packetizer
  import hnfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_nal_byte,
  input  logic [LEN_W-1:0] in_nal_length,
  input  logic             in_end_of_frame,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_packet_end,
  output logic             out_frame_marker,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  // configuration and NAL tracking state
  logic [LEN_W-1:0] max_payload_r;
  logic [LEN_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [LEN_W-1:0] frag_fill_r, frag_fill_nxt;
  logic             fragmenting_r, fragmenting_nxt;
  logic             first_frag_r, first_frag_nxt;
  logic [5:0]       unit_type_r, unit_type_nxt;

  // result queue: slot 0 is the head
  logic [7:0]       q_r [QDEPTH];
  logic [7:0]       q_nxt [QDEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic             mark_r, mark_nxt;

  // decode signals
  logic             in_take, out_take;
  logic [LEN_W-1:0] len_eff, maxp, room, fill_cur, fill_inc, remaining;
  logic             pos_zero, nal_end, frag_cur, first_cur, hdr_needed, pend_cur;
  logic [7:0]       fu_hdr;
  logic [CNT_W-1:0] emit_cnt;

  assign out_take  = out_valid && !out_stall;
  assign in_stall  = !((cnt_r == CNT_NONE) || ((cnt_r == CNT_ONE) && out_take));
  assign in_take   = in_valid && !in_stall;

  assign out_valid        = (cnt_r != CNT_NONE);
  assign out_byte         = q_r[0];
  assign out_packet_end   = pend_r && (cnt_r == CNT_ONE);
  assign out_frame_marker = mark_r && (cnt_r == CNT_ONE);

  // decode one NAL byte: mode, FU header and the bookkeeping for the next byte
  always_comb begin
    len_eff   = (in_nal_length == '0) ? {{(LEN_W-1){1'b0}}, 1'b1} : in_nal_length;
    maxp      = (max_payload_r < MAXP_MIN) ? MAXP_MIN : max_payload_r;
    room      = maxp - HDR_SIZE;
    pos_zero  = (byte_pos_r == '0);
    nal_end   = ({1'b0, byte_pos_r} + {{LEN_W{1'b0}}, 1'b1}) >= {1'b0, len_eff};
    frag_cur  = pos_zero ? (len_eff > maxp) : fragmenting_r;
    fill_cur  = pos_zero ? '0 : frag_fill_r;
    first_cur = pos_zero ? 1'b1 : first_frag_r;
    remaining = (len_eff > byte_pos_r) ? (len_eff - byte_pos_r)
                                       : {{(LEN_W-1){1'b0}}, 1'b1};
    hdr_needed = (fill_cur == '0);
    fill_inc   = fill_cur + {{(LEN_W-1){1'b0}}, 1'b1};
    pend_cur   = nal_end || (fill_inc >= room);

    fu_hdr = {2'b00, unit_type_r & TYPE_MASK};
    if (first_cur) begin
      fu_hdr = fu_hdr | S_BIT;
    end
    if (remaining <= room) begin
      fu_hdr = fu_hdr | E_BIT;
    end

    emit_cnt       = CNT_NONE;
    pend_nxt       = pend_r;
    mark_nxt       = mark_r;
    unit_type_nxt  = unit_type_r;
    frag_fill_nxt  = fill_cur;
    first_frag_nxt = first_cur;
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end

    if (out_take) begin
      // advance the queue by one byte
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      q_nxt[QDEPTH-1] = q_r[QDEPTH-1];
    end

    if (in_take) begin
      if (!frag_cur) begin
        // pass through unchanged
        emit_cnt = CNT_ONE;
        q_nxt[0] = in_nal_byte;
        pend_nxt = nal_end;
        mark_nxt = nal_end && in_end_of_frame;
      end else if (pos_zero) begin
        // first header byte: keep the type, drop the byte
        unit_type_nxt = in_nal_byte[6:1] & TYPE_MASK;
      end else if (byte_pos_r != {{(LEN_W-1){1'b0}}, 1'b1}) begin
        if (hdr_needed) begin
          emit_cnt       = CNT_FU;
          q_nxt[0]       = FU_TYPE_BYTE;
          q_nxt[1]       = FU_TID_BYTE;
          q_nxt[2]       = fu_hdr;
          q_nxt[3]       = in_nal_byte;
          first_frag_nxt = 1'b0;
        end else begin
          emit_cnt = CNT_ONE;
          q_nxt[0] = in_nal_byte;
        end
        pend_nxt      = pend_cur;
        mark_nxt      = nal_end && in_end_of_frame;
        frag_fill_nxt = pend_cur ? '0 : fill_inc;
      end
      // second header byte in FU mode: drop
    end

    if (in_take) begin
      cnt_nxt = emit_cnt;
    end else if (out_take) begin
      cnt_nxt = cnt_r - CNT_ONE;
    end else begin
      cnt_nxt = cnt_r;
    end

    // NAL position tracking
    byte_pos_nxt    = byte_pos_r;
    fragmenting_nxt = fragmenting_r;
    if (in_take) begin
      if (nal_end) begin
        byte_pos_nxt    = '0;
        frag_fill_nxt   = '0;
        fragmenting_nxt = 1'b0;
        first_frag_nxt  = 1'b1;
      end else begin
        byte_pos_nxt    = byte_pos_r + {{(LEN_W-1){1'b0}}, 1'b1};
        fragmenting_nxt = frag_cur;
      end
    end else begin
      frag_fill_nxt  = frag_fill_r;
      first_frag_nxt = first_frag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAXP_RESET;
      byte_pos_r    <= '0;
      frag_fill_r   <= '0;
      fragmenting_r <= 1'b0;
      first_frag_r  <= 1'b1;
      unit_type_r   <= '0;
      cnt_r         <= CNT_NONE;
      pend_r        <= 1'b0;
      mark_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_payload_r <= cfg_wr_data;
      end
      byte_pos_r    <= byte_pos_nxt;
      frag_fill_r   <= frag_fill_nxt;
      fragmenting_r <= fragmenting_nxt;
      first_frag_r  <= first_frag_nxt;
      unit_type_r   <= unit_type_nxt;
      cnt_r         <= cnt_nxt;
      pend_r        <= pend_nxt;
      mark_r        <= mark_nxt;
    end
  end

  // payload bytes need no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for hevc_nal_fu_packetizer: NAL bytes in, RTP payload bytes out.
// Depends on hnfp_pkg and the packetiser RTL; it carries its own byte-level predictor.
module tb_top;
  import hnfp_pkg::*;

  // Cycles with no request moving on either channel before the run is abandoned.
  // The slowest legal stretch is a long sink stall or a long source gap,
  // or a drain plus settle at a phase change.
  localparam int unsigned STALL_LIMIT   = 2000;
  // A request is decoded in the cycle it is taken and its bytes follow from
  // the next cycle, so this settle covers one that yields nothing.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 40;

  typedef struct {
    logic [7:0] data;
    logic       pkt_end;
    logic       marker;
  } rtp_byte_t;

  // Predicts the payload bytes for each accepted NAL byte, then matches them
  // against the bytes the block hands out, oldest first.
  class fu_scoreboard;
    logic [LEN_W-1:0] max_payload;
    logic [LEN_W-1:0] nal_pos;
    int unsigned      frag_fill;
    bit               in_fu_mode;
    bit               start_pending;
    logic [5:0]       hdr_type;
    rtp_byte_t        payload_q[$];
    int unsigned      mismatches;
    int unsigned      requests_noted;
    int unsigned      bytes_checked;
    int unsigned      packets_seen;
    int unsigned      fu_packets;

    function new();
      max_payload   = MAXP_RESET;
      nal_pos       = '0;
      frag_fill     = 0;
      in_fu_mode    = 1'b0;
      start_pending = 1'b1;
      hdr_type      = '0;
    endfunction

    function void set_max_payload(logic [LEN_W-1:0] value);
      max_payload = value;
    endfunction

    function int unsigned pending();
      return payload_q.size();
    endfunction

    function void queue_byte(logic [7:0] data, logic pkt_end, logic marker);
      rtp_byte_t item;
      item.data    = data;
      item.pkt_end = pkt_end;
      item.marker  = marker;
      payload_q.push_back(item);
    endfunction

    function void note_request(logic [7:0] nal_byte, logic [LEN_W-1:0] nal_length, logic eof);
      int unsigned eff_maxp;
      int unsigned room;
      int unsigned len;
      int unsigned pos;
      int unsigned remaining;
      logic [7:0]  fu_hdr;
      bit          closes_nal;
      bit          closes_packet;
      requests_noted++;
      eff_maxp   = (max_payload < MAXP_MIN) ? MAXP_MIN : max_payload;
      room       = eff_maxp - HDR_SIZE;
      len        = (nal_length == 0) ? 1 : nal_length;
      pos        = nal_pos;
      closes_nal = (pos + 1 >= len);
      // The mode is fixed by the length seen on the first byte of a NAL.
      if (pos == 0) begin
        in_fu_mode    = (len > eff_maxp);
        frag_fill     = 0;
        start_pending = 1'b1;
      end
      if (!in_fu_mode) begin
        queue_byte(nal_byte, closes_nal, closes_nal && eof);
      end else if (pos == 0) begin
        hdr_type = nal_byte[6:1] & TYPE_MASK;
      end else if (pos >= 2) begin
        if (frag_fill == 0) begin
          remaining = (len > pos) ? len - pos : 1;
          fu_hdr    = {2'b00, hdr_type};
          if (start_pending) fu_hdr = fu_hdr | S_BIT;
          if (remaining <= room) fu_hdr = fu_hdr | E_BIT;
          start_pending = 1'b0;
          fu_packets++;
          queue_byte(FU_TYPE_BYTE, 1'b0, 1'b0);
          queue_byte(FU_TID_BYTE, 1'b0, 1'b0);
          queue_byte(fu_hdr, 1'b0, 1'b0);
        end
        frag_fill++;
        closes_packet = closes_nal || (frag_fill >= room);
        queue_byte(nal_byte, closes_packet, closes_nal && eof);
        if (closes_packet) frag_fill = 0;
      end
      if (closes_nal) begin
        nal_pos       = '0;
        frag_fill     = 0;
        in_fu_mode    = 1'b0;
        start_pending = 1'b1;
      end else begin
        nal_pos = LEN_W'(pos + 1);
      end
    endfunction

    function void check_result(logic [7:0] data, logic pkt_end, logic marker);
      rtp_byte_t want;
      if (payload_q.size() == 0) begin
        $error("unexpected payload byte %0h (packet_end %0b, frame_marker %0b)",
               data, pkt_end, marker);
        mismatches++;
        return;
      end
      want = payload_q.pop_front();
      bytes_checked++;
      if (pkt_end === 1'b1) packets_seen++;
      if (data !== want.data) begin
        $error("out_byte: expected %0h, got %0h", want.data, data);
        mismatches++;
      end
      if (pkt_end !== want.pkt_end) begin
        $error("out_packet_end: expected %0b, got %0b", want.pkt_end, pkt_end);
        mismatches++;
      end
      if (marker !== want.marker) begin
        $error("out_frame_marker: expected %0b, got %0b", want.marker, marker);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       in_nal_byte;
  logic [LEN_W-1:0] in_nal_length;
  logic             in_end_of_frame;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_byte;
  logic             out_packet_end;
  logic             out_frame_marker;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  fu_scoreboard     sb = new();
  logic [LEN_W-1:0] cur_maxp;
  bit               calm;
  int unsigned      settings_used;
  int unsigned      idle_cycles;
  int unsigned      sink_hold;
  int unsigned      sink_roll;

  hevc_nal_fu_packetizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_nal_byte     (in_nal_byte),
    .in_nal_length   (in_nal_length),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_packet_end  (out_packet_end),
    .out_frame_marker(out_frame_marker),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Sink: alternate free-running bursts with short stalls and the odd long
  // one; hold the port open during a calm stretch once the current hold ends.
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 50) begin
        out_stall <= 1'b0;
        sink_hold <= $urandom_range(0, 7);
      end else if (sink_roll < 90) begin
        out_stall <= 1'b1;
        sink_hold <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        sink_hold <= $urandom_range(9, 39);
      end
    end
  end

  // Check every payload byte taken at this edge; values read here are the
  // ones held across the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_byte, out_packet_end, out_frame_marker);
  end

  // Watchdog: give up once neither channel has moved a request for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one NAL byte, hold it until taken, then note it. Valid stays
  // high for the next request unless a gap is drawn.
  task automatic push_request(logic [7:0] nal_byte, logic [LEN_W-1:0] nal_length, logic eof);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_nal_byte     <= nal_byte;
    in_nal_length   <= nal_length;
    in_end_of_frame <= eof;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(nal_byte, nal_length, eof);
  endtask

  // Drain every expected byte, let any silent request settle, then write.
  task automatic write_max_payload(logic [LEN_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_max_payload(value);
    cur_maxp = value;
    settings_used++;
  endtask

  task automatic send_nal(int unsigned len, logic eof);
    int unsigned i;
    for (i = 0; i < len; i++)
      push_request(8'($urandom_range(0, 255)), LEN_W'(len), eof);
  endtask

  // Open a NAL with a long length, then shrink it so that it closes early;
  // a close on the second byte of a fragmented NAL yields nothing at all.
  task automatic send_truncated_nal();
    int unsigned n;
    int unsigned i;
    logic [LEN_W-1:0] long_len;
    n        = $urandom_range(1, 12);
    long_len = LEN_W'($urandom_range(n + 1, 65535));
    for (i = 0; i < n; i++)
      push_request(8'($urandom_range(0, 255)), long_len, 1'($urandom_range(0, 1)));
    push_request(8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, n + 1)),
                 1'($urandom_range(0, 1)));
  endtask

  // Mostly well-formed NALs sized around the current limit so that both the
  // pass-through and the fragmenting paths see traffic; the rest is noise.
  task automatic send_random_sequence();
    int unsigned eff;
    int unsigned roll;
    int unsigned len;
    int unsigned cap;
    eff  = (cur_maxp < MAXP_MIN) ? MAXP_MIN : cur_maxp;
    roll = $urandom_range(0, 99);
    calm = ($urandom_range(0, 9) == 0);
    if (roll < 75) begin
      if (eff <= 40 && $urandom_range(0, 1) == 1) begin
        cap = eff + 2 + ((3 * (eff - 3) < 40) ? 3 * (eff - 3) : 40);
        case ($urandom_range(0, 3))
          0:       len = eff;
          1:       len = eff + 1;
          default: len = $urandom_range(eff + 1, cap);
        endcase
      end else begin
        len = $urandom_range(1, (eff < 24) ? eff : 24);
      end
      send_nal(len, 1'($urandom_range(0, 1)));
    end else if (roll < 90) begin
      send_truncated_nal();
    end else begin
      push_request(8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
    end
  endtask

  logic [LEN_W-1:0] phase_maxp[$];

  initial begin
    in_valid        <= 1'b0;
    in_nal_byte     <= '0;
    in_nal_length   <= '0;
    in_end_of_frame <= 1'b0;
    out_stall       <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    rst_n           <= 1'b0;
    sink_hold       = 0;
    idle_cycles     = 0;
    calm            = 1'b0;
    settings_used   = 1;
    cur_maxp        = MAXP_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: pass-through at the reset limit, including a zero length
    // that acts as one and a single-byte NAL.
    push_request(8'h00, 16'd0, 1'b1);
    push_request(8'hFF, 16'd1, 1'b0);
    push_request(8'h80, 16'd3, 1'b1);
    push_request(8'h01, 16'd3, 1'b1);
    push_request(8'hFE, 16'd3, 1'b1);

    // Smallest limit: one data byte per fragment, header type all ones.
    write_max_payload(16'd4);
    push_request(8'h7E, 16'd6, 1'b1);
    push_request(8'h01, 16'd6, 1'b1);
    push_request(8'hAA, 16'd6, 1'b1);
    push_request(8'h55, 16'd6, 1'b1);
    push_request(8'h00, 16'd6, 1'b1);
    push_request(8'hFF, 16'd6, 1'b1);
    push_request(8'h02, 16'd5, 1'b0);
    push_request(8'h01, 16'd5, 1'b0);
    push_request(8'h3C, 16'd5, 1'b0);
    push_request(8'hC3, 16'd5, 1'b0);
    push_request(8'h99, 16'd5, 1'b0);

    // Limit below the floor acts as four. A fragmented NAL that closes on its
    // second header byte, then one that shrinks so the last fragment is cut.
    write_max_payload(16'd0);
    push_request(8'h40, 16'hFFFF, 1'b0);
    push_request(8'h01, 16'd2, 1'b1);
    push_request(8'h26, 16'd6, 1'b0);
    push_request(8'h01, 16'd6, 1'b0);
    push_request(8'h11, 16'd6, 1'b0);
    push_request(8'h22, 16'd3, 1'b1);

    // Random phases across several limits, the extremes among them.
    phase_maxp = '{16'd4, 16'd65535, 16'd5, 16'd7, 16'd3, 16'd12,
                   16'($urandom_range(4, 40)), 16'd1400, 16'($urandom), 16'd20};
    foreach (phase_maxp[p]) begin
      int unsigned phase_start;
      write_max_payload(phase_maxp[p]);
      phase_start = sb.requests_noted;
      while (sb.requests_noted - phase_start < PHASE_ITEMS)
        send_random_sequence();
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d NAL byte requests over %0d max_payload settings.",
             sb.requests_noted, settings_used);
    $display("Checked %0d payload bytes in %0d packets, %0d of them fragments.",
             sb.bytes_checked, sb.packets_seen, sb.fu_packets);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
